### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the tag alias chain resolver RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with synchronous active-low reset disable.
`define TACR_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Shorthand on the block's standard clock and reset.
`define TACR_ASSERT_CLK(name, prop, msg) `TACR_ASSERT(name, i_clk, i_rst_n, prop, msg)

`endif

### rtl/core/tacr_pkg.sv
// ----------------------------------------------------------------------------
// tacr_pkg
// Shared types and constants of the tag alias chain resolver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tacr_pkg;

    localparam int P_PROG_DEPTH = 64;
    localparam int P_CTRL_DEPTH = 256;

    localparam int KEY_W  = 16;
    localparam int TYPE_W = 16;

    localparam int B_NOT_ALIAS  = 26;
    localparam int B_PROG_SCOPE = 17;
    localparam int B_CTRL_SCOPE = 16;

    localparam int          TYPE_SHIFT   = 12;
    localparam logic [3:0]  TYPE_BAD_TOP = 4'd1;

    localparam logic [1:0] CMD_APPEND_PROG = 2'd0;
    localparam logic [1:0] CMD_APPEND_CTRL = 2'd1;
    localparam logic [1:0] CMD_CLEAR       = 2'd2;
    localparam logic [1:0] CMD_RESOLVE     = 2'd3;

    localparam logic [2:0] ST_PROG_HIT  = 3'd0;
    localparam logic [2:0] ST_CTRL_HIT  = 3'd1;
    localparam logic [2:0] ST_NOT_ALIAS = 3'd2;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
    localparam logic [2:0] ST_BROKEN    = 3'd4;
    localparam logic [2:0] ST_NO_SCOPE  = 3'd5;
    localparam logic [2:0] ST_ACK       = 3'd6;

    // first member sits in the top bits, so key lands at bit 0
    typedef struct packed {
        logic [TYPE_W-1:0] tag_type;
        logic [31:0]       tag_link;
        logic [31:0]       tag_size;
        logic [31:0]       tag_topbase;
        logic [31:0]       entry_key;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

### rtl/core/tacr_table.sv
// ----------------------------------------------------------------------------
// tacr_table
// Single-port-write, single-port-read tag table memory with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tacr_table #(
    parameter int DEPTH = tacr_pkg::P_PROG_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire tacr_pkg::t_entry i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output tacr_pkg::t_entry      o_rd_data
);
    import tacr_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/core/tacr_walker.sv
// ----------------------------------------------------------------------------
// tacr_walker
// Command sequencer: appends, clears, and walks alias chains over the tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tacr_walker #(
    parameter int PROG_DEPTH = tacr_pkg::P_PROG_DEPTH,
    parameter int CTRL_DEPTH = tacr_pkg::P_CTRL_DEPTH,
    parameter int PAW = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1,
    parameter int CAW = (CTRL_DEPTH > 1) ? $clog2(CTRL_DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [1:0]       i_in_cmd,
    input  wire tacr_pkg::t_entry i_in_entry,
    output logic                  o_prog_wr_en,
    output logic [PAW-1:0]        o_prog_wr_addr,
    output logic                  o_ctrl_wr_en,
    output logic [CAW-1:0]        o_ctrl_wr_addr,
    output tacr_pkg::t_entry      o_wr_data,
    output logic                  o_prog_rd_en,
    output logic [PAW-1:0]        o_prog_rd_addr,
    input  wire tacr_pkg::t_entry i_prog_rd_data,
    output logic                  o_ctrl_rd_en,
    output logic [CAW-1:0]        o_ctrl_rd_addr,
    input  wire tacr_pkg::t_entry i_ctrl_rd_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [2:0]            o_out_status,
    output logic                  o_out_full,
    output tacr_pkg::t_entry      o_out_entry
);
    import tacr_pkg::*;

    localparam int PCW = $clog2(PROG_DEPTH + 1);
    localparam int CCW = $clog2(CTRL_DEPTH + 1);
    localparam int IW  = (PCW > CCW) ? PCW : CCW;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic TBL_PROG = 1'b0;
    localparam logic TBL_CTRL = 1'b1;

    logic [1:0]        r_state, n_state;
    logic [PCW-1:0]    r_prog_cnt, n_prog_cnt;
    logic [CCW-1:0]    r_ctrl_cnt, n_ctrl_cnt;
    logic              r_tbl, n_tbl;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [IW-1:0]     r_idx, n_idx;
    logic [IW-1:0]     r_hop, n_hop;
    logic              r_pend, n_pend;
    logic [2:0]        r_res_status, n_res_status;
    logic              r_res_full, n_res_full;
    t_entry            r_res_entry, n_res_entry;
    logic              r_out_valid, n_out_valid;
    logic [2:0]        r_out_status;
    logic              r_out_full;
    t_entry            r_out_entry;

    logic              accept;
    logic              out_load;
    logic [IW-1:0]     act_cnt;
    t_entry            rd_entry;
    logic [31:0]       rd_top;
    logic [31:0]       in_top;
    logic              hit;

    assign accept   = i_in_valid && o_in_ready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign act_cnt  = (r_tbl == TBL_CTRL) ? IW'(r_ctrl_cnt) : IW'(r_prog_cnt);
    assign rd_entry = (r_tbl == TBL_CTRL) ? i_ctrl_rd_data : i_prog_rd_data;
    assign rd_top   = rd_entry.tag_topbase;
    assign in_top   = i_in_entry.tag_topbase;
    assign hit      = r_pend && (rd_entry.entry_key == {{(32-KEY_W){1'b0}}, r_key});

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_wr_data      = i_in_entry;
    assign o_prog_wr_addr = r_prog_cnt[PAW-1:0];
    assign o_ctrl_wr_addr = r_ctrl_cnt[CAW-1:0];
    assign o_prog_rd_en   = (r_state == S_SCAN) && (r_tbl == TBL_PROG) && (r_idx != act_cnt);
    assign o_ctrl_rd_en   = (r_state == S_SCAN) && (r_tbl == TBL_CTRL) && (r_idx != act_cnt);
    assign o_prog_rd_addr = r_idx[PAW-1:0];
    assign o_ctrl_rd_addr = r_idx[CAW-1:0];

    always_comb begin
        n_state      = r_state;
        n_prog_cnt   = r_prog_cnt;
        n_ctrl_cnt   = r_ctrl_cnt;
        n_tbl        = r_tbl;
        n_key        = r_key;
        n_idx        = r_idx;
        n_hop        = r_hop;
        n_pend       = r_pend;
        n_res_status = r_res_status;
        n_res_full   = r_res_full;
        n_res_entry  = r_res_entry;
        n_out_valid  = r_out_valid;
        o_prog_wr_en = 1'b0;
        o_ctrl_wr_en = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_status = ST_ACK;
                    n_res_full   = 1'b0;
                    n_res_entry  = '0;
                    n_state      = S_DONE;
                    case (i_in_cmd)
                        CMD_APPEND_PROG: begin
                            if (r_prog_cnt == PCW'(PROG_DEPTH)) begin
                                n_res_full = 1'b1;
                            end else begin
                                o_prog_wr_en = 1'b1;
                                n_prog_cnt   = r_prog_cnt + 1'b1;
                            end
                        end
                        CMD_APPEND_CTRL: begin
                            if (r_ctrl_cnt == CCW'(CTRL_DEPTH)) begin
                                n_res_full = 1'b1;
                            end else begin
                                o_ctrl_wr_en = 1'b1;
                                n_ctrl_cnt   = r_ctrl_cnt + 1'b1;
                            end
                        end
                        CMD_CLEAR: begin
                            n_prog_cnt = '0;
                            n_ctrl_cnt = '0;
                        end
                        default: begin
                            n_key  = in_top[KEY_W-1:0];
                            n_idx  = '0;
                            n_hop  = '0;
                            n_pend = 1'b0;
                            if (i_in_entry.tag_type[TYPE_W-1:TYPE_SHIFT] == TYPE_BAD_TOP) begin
                                n_res_status = ST_BAD_TYPE;
                            end else if (in_top[B_NOT_ALIAS]) begin
                                n_res_status = ST_NOT_ALIAS;
                            end else if (in_top[B_PROG_SCOPE]) begin
                                n_tbl   = TBL_PROG;
                                n_state = S_SCAN;
                            end else if (in_top[B_CTRL_SCOPE]) begin
                                n_tbl   = TBL_CTRL;
                                n_state = S_SCAN;
                            end else begin
                                n_res_status = ST_NO_SCOPE;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_res_full  = 1'b0;
                n_res_entry = '0;
                if (hit) begin
                    n_key  = rd_top[KEY_W-1:0];
                    n_idx  = '0;
                    n_pend = 1'b0;
                    n_hop  = r_hop + 1'b1;
                    if (r_tbl == TBL_PROG) begin
                        if (rd_top[B_NOT_ALIAS] || !rd_top[B_PROG_SCOPE]) begin
                            if (rd_top[B_PROG_SCOPE]) begin
                                n_res_status = ST_PROG_HIT;
                                n_res_entry  = rd_entry;
                                n_state      = S_DONE;
                            end else begin
                                n_tbl = TBL_CTRL;
                                n_hop = '0;
                            end
                        end else if (r_hop == IW'(PROG_DEPTH - 1)) begin
                            n_res_status = ST_BROKEN;
                            n_state      = S_DONE;
                        end
                    end else begin
                        if (rd_top[B_NOT_ALIAS]) begin
                            n_res_status = ST_CTRL_HIT;
                            n_res_entry  = rd_entry;
                            n_state      = S_DONE;
                        end else if (r_hop == IW'(CTRL_DEPTH - 1)) begin
                            n_res_status = ST_BROKEN;
                            n_state      = S_DONE;
                        end
                    end
                end else if (r_idx == act_cnt) begin
                    n_res_status = ST_BROKEN;
                    n_pend       = 1'b0;
                    n_state      = S_DONE;
                end else begin
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prog_cnt  <= '0;
            r_ctrl_cnt  <= '0;
            r_tbl       <= TBL_PROG;
            r_key       <= '0;
            r_idx       <= '0;
            r_hop       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prog_cnt  <= n_prog_cnt;
            r_ctrl_cnt  <= n_ctrl_cnt;
            r_tbl       <= n_tbl;
            r_key       <= n_key;
            r_idx       <= n_idx;
            r_hop       <= n_hop;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_status <= n_res_status;
        r_res_full   <= n_res_full;
        r_res_entry  <= n_res_entry;
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_full   <= r_res_full;
            r_out_entry  <= r_res_entry;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_full   = r_out_full;
    assign o_out_entry  = r_out_entry;

    `TACR_ASSERT_CLK(a_full_only_on_ack,
        r_out_valid && r_out_full |-> r_out_status == ST_ACK,
        "table_full set on a non-ack result")
    `TACR_ASSERT_CLK(a_miss_fields_zero,
        r_out_valid && r_out_status != ST_PROG_HIT && r_out_status != ST_CTRL_HIT
            |-> r_out_entry == '0,
        "entry fields nonzero on a non-hit result")
    `TACR_ASSERT_CLK(a_prog_append_counts,
        accept && i_in_cmd == CMD_APPEND_PROG && r_prog_cnt != PCW'(PROG_DEPTH)
            |=> r_prog_cnt == $past(r_prog_cnt) + 1'b1,
        "program count did not advance on append")
    `TACR_ASSERT_CLK(a_scan_in_bounds,
        r_state == S_SCAN |-> r_idx <= act_cnt,
        "scan index beyond table fill")

endmodule

`default_nettype wire

### rtl/core/tag_alias_chain_resolver.sv
// Append or clear: the result passes through the result register, then the output register.
// Resolve: each hop scans its table from entry 0 until the key matches, or up to the fill
// count when the key is missing; each table memory's single read port scans one entry
// per cycle. Requests: a new request is taken the cycle after the result moves to the
// output register, so no new request is taken while one is still in the walker.
// Reset: synchronous, active low; clears fill counts and control, table contents undefined.
// ----------------------------------------------------------------------------
// tag_alias_chain_resolver
// Two-scope tag tables with alias chain resolution over streaming ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tag_alias_chain_resolver #(
    parameter int PROG_DEPTH = tacr_pkg::P_PROG_DEPTH,
    parameter int CTRL_DEPTH = tacr_pkg::P_CTRL_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // entry_key, tag_topbase, tag_size, tag_link, tag_type
    input  wire logic [tacr_pkg::ENTRY_W-1:0]  s_axis_tdata,
    // cmd
    input  wire logic [1:0]                    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // found_key, found_topbase, found_size, found_link, found_type
    output logic [tacr_pkg::ENTRY_W-1:0]       m_axis_tdata,
    // status, table_full
    output logic [3:0]                         m_axis_tuser
);
    import tacr_pkg::*;

    localparam int PAW = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
    localparam int CAW = (CTRL_DEPTH > 1) ? $clog2(CTRL_DEPTH) : 1;

    logic           prog_wr_en;
    logic [PAW-1:0] prog_wr_addr;
    logic           ctrl_wr_en;
    logic [CAW-1:0] ctrl_wr_addr;
    t_entry         wr_data;
    logic           prog_rd_en;
    logic [PAW-1:0] prog_rd_addr;
    t_entry         prog_rd_data;
    logic           ctrl_rd_en;
    logic [CAW-1:0] ctrl_rd_addr;
    t_entry         ctrl_rd_data;
    logic [2:0]     out_status;
    logic           out_full;
    t_entry         out_entry;

    tacr_table #(
        .DEPTH (PROG_DEPTH),
        .AW    (PAW)
    ) u_prog_table (
        .i_clk     (i_clk),
        .i_wr_en   (prog_wr_en),
        .i_wr_addr (prog_wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (prog_rd_en),
        .i_rd_addr (prog_rd_addr),
        .o_rd_data (prog_rd_data)
    );

    tacr_table #(
        .DEPTH (CTRL_DEPTH),
        .AW    (CAW)
    ) u_ctrl_table (
        .i_clk     (i_clk),
        .i_wr_en   (ctrl_wr_en),
        .i_wr_addr (ctrl_wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (ctrl_rd_en),
        .i_rd_addr (ctrl_rd_addr),
        .o_rd_data (ctrl_rd_data)
    );

    tacr_walker #(
        .PROG_DEPTH (PROG_DEPTH),
        .CTRL_DEPTH (CTRL_DEPTH),
        .PAW        (PAW),
        .CAW        (CAW)
    ) u_walker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_in_cmd       (s_axis_tuser),
        .i_in_entry     (t_entry'(s_axis_tdata)),
        .o_prog_wr_en   (prog_wr_en),
        .o_prog_wr_addr (prog_wr_addr),
        .o_ctrl_wr_en   (ctrl_wr_en),
        .o_ctrl_wr_addr (ctrl_wr_addr),
        .o_wr_data      (wr_data),
        .o_prog_rd_en   (prog_rd_en),
        .o_prog_rd_addr (prog_rd_addr),
        .i_prog_rd_data (prog_rd_data),
        .o_ctrl_rd_en   (ctrl_rd_en),
        .o_ctrl_rd_addr (ctrl_rd_addr),
        .i_ctrl_rd_data (ctrl_rd_data),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_out_status   (out_status),
        .o_out_full     (out_full),
        .o_out_entry    (out_entry)
    );

    assign m_axis_tdata = out_entry;
    assign m_axis_tuser = {out_full, out_status};

endmodule

`default_nettype wire

### dv/tag_alias_chain_resolver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tag_alias_chain_resolver_tb
// Self-checking bench for the tag alias chain resolver. A directed set of
// requests covers the error statuses, scope fall-through, unmatched upper key
// bits and endless chains. Random rounds follow: they fill the program and
// controller tables with short alias chains and then resolve into them, with
// full-table rounds and stray requests mixed in. A local copy of both tables
// predicts each reply that a directed row does not fix, and replies are checked
// in order while both stream sides idle at random outside a calm stretch.
// ----------------------------------------------------------------------------
module tag_alias_chain_resolver_tb;
    import tacr_pkg::*;

    localparam int IDLE_PCT      = 27;
    localparam int RANDOM_ITEMS  = 1900;
    localparam int STALL_LIMIT   = 300000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int NUM_DIRECTED  = 25;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [2:0] status;
        logic       full;
        t_entry     found;
    } t_reply;

    typedef struct {
        logic [1:0] cmd;
        t_entry     req;
        bit         typed;
        t_reply     want;
    } t_row;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    t_entry             s_data  = '0;
    logic [1:0]         s_cmd   = CMD_CLEAR;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [ENTRY_W-1:0] m_data;
    logic [3:0]         m_user;

    t_entry prog_tab [P_PROG_DEPTH];
    t_entry ctrl_tab [P_CTRL_DEPTH];
    int     prog_fill = 0;
    int     ctrl_fill = 0;

    t_reply pending_replies [$];
    t_row   directed_rows [NUM_DIRECTED];
    int     mismatches   = 0;
    int     stall_cycles = 0;
    int     accepted     = 0;
    bit     calm         = 1'b0;

    tag_alias_chain_resolver u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_cmd),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_reply plain_reply(logic [2:0] status, logic full);
        t_reply r;
        r        = '0;
        r.status = status;
        r.full   = full;
        return r;
    endfunction

    function automatic int prog_index(logic [KEY_W-1:0] key);
        for (int i = 0; i < prog_fill; i++) begin
            if (prog_tab[i].entry_key == {16'h0, key}) return i;
        end
        return prog_fill;
    endfunction

    function automatic int ctrl_index(logic [KEY_W-1:0] key);
        for (int i = 0; i < ctrl_fill; i++) begin
            if (ctrl_tab[i].entry_key == {16'h0, key}) return i;
        end
        return ctrl_fill;
    endfunction

    function automatic t_reply walk_ctrl_chain(logic [KEY_W-1:0] start);
        t_reply           r;
        logic [KEY_W-1:0] key;
        int               idx;
        r   = plain_reply(ST_BROKEN, 1'b0);
        key = start;
        for (int hop = 0; hop < P_CTRL_DEPTH; hop++) begin
            idx = ctrl_index(key);
            if (idx >= ctrl_fill) return r;
            key = ctrl_tab[idx].tag_topbase[KEY_W-1:0];
            if (ctrl_tab[idx].tag_topbase[B_NOT_ALIAS]) begin
                r.status = ST_CTRL_HIT;
                r.found  = ctrl_tab[idx];
                return r;
            end
        end
        return r;
    endfunction

    function automatic t_reply walk_prog_chain(logic [KEY_W-1:0] start);
        t_reply           r;
        logic [KEY_W-1:0] key;
        logic [31:0]      top;
        int               idx;
        r   = plain_reply(ST_BROKEN, 1'b0);
        key = start;
        for (int hop = 0; hop < P_PROG_DEPTH; hop++) begin
            idx = prog_index(key);
            if (idx >= prog_fill) return r;
            top = prog_tab[idx].tag_topbase;
            key = top[KEY_W-1:0];
            if (top[B_NOT_ALIAS] || !top[B_PROG_SCOPE]) begin
                if (!top[B_PROG_SCOPE]) return walk_ctrl_chain(key);
                r.status = ST_PROG_HIT;
                r.found  = prog_tab[idx];
                return r;
            end
        end
        return r;
    endfunction

    function automatic t_reply predict_reply(logic [1:0] cmd, t_entry req);
        t_reply      r;
        logic [31:0] top;
        r   = plain_reply(ST_ACK, 1'b0);
        top = req.tag_topbase;
        case (cmd)
            CMD_APPEND_PROG: begin
                if (prog_fill >= P_PROG_DEPTH) begin
                    r.full = 1'b1;
                end else begin
                    prog_tab[prog_fill] = req;
                    prog_fill++;
                end
            end
            CMD_APPEND_CTRL: begin
                if (ctrl_fill >= P_CTRL_DEPTH) begin
                    r.full = 1'b1;
                end else begin
                    ctrl_tab[ctrl_fill] = req;
                    ctrl_fill++;
                end
            end
            CMD_CLEAR: begin
                prog_fill = 0;
                ctrl_fill = 0;
            end
            default: begin
                if ((req.tag_type >> TYPE_SHIFT) == TYPE_BAD_TOP) begin
                    r = plain_reply(ST_BAD_TYPE, 1'b0);
                end else if (top[B_NOT_ALIAS]) begin
                    r = plain_reply(ST_NOT_ALIAS, 1'b0);
                end else if (top[B_PROG_SCOPE]) begin
                    r = walk_prog_chain(top[KEY_W-1:0]);
                end else if (top[B_CTRL_SCOPE]) begin
                    r = walk_ctrl_chain(top[KEY_W-1:0]);
                end else begin
                    r = plain_reply(ST_NO_SCOPE, 1'b0);
                end
            end
        endcase
        return r;
    endfunction

    function automatic t_row dir_row(logic [1:0] cmd, logic [31:0] key, logic [31:0] top,
                                     logic [31:0] size, logic [31:0] link,
                                     logic [15:0] ttype, bit typed, logic [2:0] status);
        t_row row;
        row.cmd               = cmd;
        row.req.entry_key     = key;
        row.req.tag_topbase   = top;
        row.req.tag_size      = size;
        row.req.tag_link      = link;
        row.req.tag_type      = ttype;
        row.typed             = typed;
        row.want              = plain_reply(status, 1'b0);
        return row;
    endfunction

    function automatic logic [KEY_W-1:0] small_key();
        return KEY_W'($urandom_range(0, 15));
    endfunction

    function automatic t_entry random_entry(bit prog_side);
        t_entry      e;
        logic [31:0] r;
        e.entry_key = ($urandom_range(0, 9) == 0) ? $urandom : {16'h0, small_key()};
        r = $urandom;
        if ($urandom_range(0, 9) != 0) r[KEY_W-1:0] = small_key();
        r[B_NOT_ALIAS] = ($urandom_range(0, 99) < 35);
        if (prog_side) r[B_PROG_SCOPE] = ($urandom_range(0, 99) < 70);
        e.tag_topbase = r;
        e.tag_size    = $urandom;
        e.tag_link    = $urandom;
        r             = $urandom;
        e.tag_type    = r[15:0];
        return e;
    endfunction

    function automatic t_entry random_query();
        t_entry      e;
        logic [31:0] r;
        int          pick;
        e.entry_key = $urandom;
        e.tag_size  = $urandom;
        e.tag_link  = $urandom;
        r = $urandom;
        if ($urandom_range(0, 9) != 0) r[KEY_W-1:0] = small_key();
        r[B_NOT_ALIAS]  = ($urandom_range(0, 99) < 8);
        pick            = $urandom_range(0, 99);
        r[B_PROG_SCOPE] = (pick < 45) || (pick >= 85 && pick < 92);
        r[B_CTRL_SCOPE] = (pick >= 45 && pick < 92);
        e.tag_topbase   = r;
        r = $urandom;
        if ($urandom_range(0, 99) < 8) r[15:12] = TYPE_BAD_TOP;
        e.tag_type = r[15:0];
        return e;
    endfunction

    function automatic t_entry random_fields();
        t_entry      e;
        logic [31:0] r;
        e.entry_key   = $urandom;
        e.tag_topbase = $urandom;
        e.tag_size    = $urandom;
        e.tag_link    = $urandom;
        r             = $urandom;
        e.tag_type    = r[15:0];
        return e;
    endfunction

    task automatic send_request(input logic [1:0] cmd, input t_entry req, input bit typed,
                                input t_reply want);
        t_reply guess;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        s_cmd   <= cmd;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        guess = predict_reply(cmd, req);
        pending_replies.push_back(typed ? want : guess);
        accepted++;
    endtask

    task automatic report_mismatch(input string what, input t_reply want, input t_reply got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%s: exp status %0d full %0b key %h top %h size %h link %h type %h",
                     what, want.status, want.full, want.found.entry_key,
                     want.found.tag_topbase, want.found.tag_size, want.found.tag_link,
                     want.found.tag_type);
            $display("%s: got status %0d full %0b key %h top %h size %h link %h type %h",
                     what, got.status, got.full, got.found.entry_key,
                     got.found.tag_topbase, got.found.tag_size, got.found.tag_link,
                     got.found.tag_type);
        end
    endtask

    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        if (!i_rst_n) begin
            m_ready      <= 1'b0;
            stall_cycles <= 0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end else if (m_valid && m_ready) begin
                got.status = m_user[2:0];
                got.full   = m_user[3];
                got.found  = m_data;
                if (pending_replies.size() == 0) begin
                    report_mismatch("unexpected reply", '0, got);
                end else begin
                    want = pending_replies.pop_front();
                    if (want.status !== got.status || want.full !== got.full
                        || want.found.entry_key !== got.found.entry_key
                        || want.found.tag_topbase !== got.found.tag_topbase
                        || want.found.tag_size !== got.found.tag_size
                        || want.found.tag_link !== got.found.tag_link
                        || want.found.tag_type !== got.found.tag_type) begin
                        report_mismatch("reply mismatch", want, got);
                    end
                end
            end
        end
    end

    initial begin
        bit full_round;
        int episode;
        int n_prog;
        int n_ctrl;
        int n_res;
        directed_rows[0]  = dir_row(CMD_RESOLVE, 0, 32'h0002_0005, 0, 0, 16'h0000, 1, ST_BROKEN);
        directed_rows[1]  = dir_row(CMD_RESOLVE, 0, 32'h0001_0005, 0, 0, 16'h0000, 1, ST_BROKEN);
        directed_rows[2]  = dir_row(CMD_RESOLVE, 0, 32'h0000_0000, 0, 0, 16'h0000, 1,
                                    ST_NO_SCOPE);
        directed_rows[3]  = dir_row(CMD_RESOLVE, 0, 32'h0403_0000, 0, 0, 16'h0000, 1,
                                    ST_NOT_ALIAS);
        directed_rows[4]  = dir_row(CMD_RESOLVE, '1, '1, '1, '1, 16'hffff, 1, ST_NOT_ALIAS);
        directed_rows[5]  = dir_row(CMD_RESOLVE, 0, 32'h0002_0001, 0, 0, 16'h1000, 1,
                                    ST_BAD_TYPE);
        directed_rows[6]  = dir_row(CMD_RESOLVE, 0, '1, 0, 0, 16'h1fff, 1, ST_BAD_TYPE);
        directed_rows[7]  = dir_row(CMD_APPEND_PROG, 1, 32'h0002_0002, 0, 0, 16'h0000, 1,
                                    ST_ACK);
        directed_rows[8]  = dir_row(CMD_APPEND_PROG, 2, 32'h0402_0003, '1, 0, 16'hffff, 1,
                                    ST_ACK);
        directed_rows[9]  = dir_row(CMD_APPEND_PROG, 3, 32'h0000_0010, 32'h1234_5678,
                                    32'h9abc_def0, 16'h0abc, 1, ST_ACK);
        directed_rows[10] = dir_row(CMD_APPEND_CTRL, 32'h10, 32'h0001_0011, 1, 2, 16'h0003, 1,
                                    ST_ACK);
        directed_rows[11] = dir_row(CMD_APPEND_CTRL, 32'h11, 32'h0401_ffff, '1, '1, 16'hffff,
                                    1, ST_ACK);
        directed_rows[12] = dir_row(CMD_RESOLVE, 0, 32'h0002_0001, 0, 0, 16'h0000, 0,
                                    ST_PROG_HIT);
        directed_rows[13] = dir_row(CMD_RESOLVE, 0, 32'h0002_0003, 0, 0, 16'h0000, 0,
                                    ST_CTRL_HIT);
        directed_rows[14] = dir_row(CMD_RESOLVE, 0, 32'h0001_0010, 0, 0, 16'h2fff, 0,
                                    ST_CTRL_HIT);
        directed_rows[15] = dir_row(CMD_APPEND_CTRL, 32'hffff_0020, 32'h0400_0000, 0, 0,
                                    16'h0000, 1, ST_ACK);
        directed_rows[16] = dir_row(CMD_RESOLVE, 0, 32'h0001_0020, 0, 0, 16'h0000, 1,
                                    ST_BROKEN);
        directed_rows[17] = dir_row(CMD_APPEND_PROG, 7, 32'h0002_0007, 0, 0, 16'h0000, 1,
                                    ST_ACK);
        directed_rows[18] = dir_row(CMD_RESOLVE, 0, 32'h0002_0007, 0, 0, 16'h0000, 1,
                                    ST_BROKEN);
        directed_rows[19] = dir_row(CMD_APPEND_CTRL, 32'h30, 32'h0001_0030, 0, 0, 16'h0000, 1,
                                    ST_ACK);
        directed_rows[20] = dir_row(CMD_RESOLVE, 0, 32'h0001_0030, 0, 0, 16'h0000, 1,
                                    ST_BROKEN);
        directed_rows[21] = dir_row(CMD_RESOLVE, 0, 32'h0003_0001, 0, 0, 16'h0000, 0,
                                    ST_PROG_HIT);
        directed_rows[22] = dir_row(CMD_APPEND_PROG, '1, '1, '1, '1, 16'hffff, 1, ST_ACK);
        directed_rows[23] = dir_row(CMD_CLEAR, 0, 0, 0, 0, 16'h0000, 1, ST_ACK);
        directed_rows[24] = dir_row(CMD_RESOLVE, 0, 32'h0002_0001, 0, 0, 16'h0000, 1,
                                    ST_BROKEN);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].cmd, directed_rows[i].req, directed_rows[i].typed,
                         directed_rows[i].want);
        end

        episode = 0;
        while (accepted < NUM_DIRECTED + RANDOM_ITEMS) begin
            calm       = (accepted >= 700 && accepted < 1000);
            full_round = (episode == 2) || ($urandom_range(0, 29) == 0);
            n_prog     = full_round ? P_PROG_DEPTH + $urandom_range(1, 3) : $urandom_range(0, 8);
            n_ctrl     = full_round ? P_CTRL_DEPTH + $urandom_range(1, 3) : $urandom_range(0, 10);
            n_res      = full_round ? 12 : $urandom_range(3, 12);
            if (full_round || $urandom_range(0, 7) != 0) begin
                send_request(CMD_CLEAR, random_fields(), 1'b0, '0);
            end
            // interleave the two tables' appends
            while (n_prog + n_ctrl > 0) begin
                if (n_prog > 0 && (n_ctrl == 0 || $urandom_range(0, 1) == 0)) begin
                    send_request(CMD_APPEND_PROG, random_entry(1'b1), 1'b0, '0);
                    n_prog--;
                end else begin
                    send_request(CMD_APPEND_CTRL, random_entry(1'b0), 1'b0, '0);
                    n_ctrl--;
                end
            end
            repeat (n_res) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_request(2'($urandom_range(0, 3)), random_fields(), 1'b0, '0);
                end else begin
                    send_request(CMD_RESOLVE, random_query(), 1'b0, '0);
                end
            end
            episode++;
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/tacr_pkg.sv
rtl/core/tacr_table.sv
rtl/core/tacr_walker.sv
rtl/core/tag_alias_chain_resolver.sv
dv/tag_alias_chain_resolver_tb.sv
